>>> rtl/sli_pkg.sv
// Shared constants and types for the sigmoid table interpolator.
`default_nettype none

package sli_pkg;

  // Default parameter values
  localparam int unsigned TABLE_NODES_DEF            = 256;
  localparam int unsigned LOG2_NODES_PER_UNIT_DEF    = 5;
  localparam int unsigned POSITION_FRACTION_BITS_DEF = 12;

  // Fixed field widths
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned EXP_W      = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 1;

  // |code| * mantissa stays below 2^38
  localparam int unsigned MAG_W = CODE_W + MANT_W - 1;

  // Queue depths
  localparam int unsigned MID_QUEUE_DEPTH = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [MANT_W-1:0]       MANT_RESET = 31'd1073741824;
  localparam logic signed [EXP_W-1:0] EXP_RESET  = -8'sd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MANTISSA = 1'b0,
    REG_SCALE_EXPONENT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_EVAL = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

endpackage

`default_nettype wire

>>> rtl/sli_fifo.sv
// Small register queue with count-based full, used between pipeline sections.
`default_nettype none

module sli_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q < CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && count_q == '0) |=> valid_o)
    else $error("pushed word not visible");

endmodule

`default_nettype wire

>>> rtl/sli_front.sv
// Front section: scales the code into a clamped table position, passes table loads along.
`default_nettype none

module sli_front #(
  parameter int unsigned TABLE_NODES            = sli_pkg::TABLE_NODES_DEF,
  parameter int unsigned LOG2_NODES_PER_UNIT    = sli_pkg::LOG2_NODES_PER_UNIT_DEF,
  parameter int unsigned POSITION_FRACTION_BITS = sli_pkg::POSITION_FRACTION_BITS_DEF,
  parameter int unsigned IDX_W                  = $clog2(TABLE_NODES + 1)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    mode_i,
  input  logic signed [sli_pkg::CODE_W-1:0]       code_i,
  input  logic [IDX_W-1:0]                        entry_index_i,
  input  logic [sli_pkg::VALUE_W-1:0]             entry_value_i,
  input  logic [sli_pkg::MANT_W-1:0]              mantissa_i,
  input  logic signed [sli_pkg::EXP_W-1:0]        exponent_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    out_load_o,
  output logic [IDX_W-1:0]                        out_index_o,
  output logic [sli_pkg::VALUE_W-1:0]             out_value_o,
  output logic [POSITION_FRACTION_BITS:0]         out_weight_o
);

  localparam int unsigned F      = POSITION_FRACTION_BITS;
  localparam int unsigned MAG_W  = sli_pkg::MAG_W;
  localparam int unsigned POS_W  = $clog2(TABLE_NODES) + F + 1;
  localparam int unsigned SH_W   = sli_pkg::EXP_W + 2;
  localparam int unsigned WIDE_W = MAG_W + POS_W;
  localparam int unsigned MUL_W  = sli_pkg::CODE_W + sli_pkg::MANT_W;
  localparam logic [POS_W-1:0] TOP_POS  = POS_W'(TABLE_NODES << F);
  localparam logic [POS_W-1:0] HALF_POS = POS_W'((TABLE_NODES << F) / 2);
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(TABLE_NODES - 1);
  localparam logic [F:0]       W_ONE    = (F + 1)'(1) << F;

  // stage 1: magnitude product and total shift
  logic                          s1_v_q;
  logic                          s1_load_q, s1_neg_q;
  logic [MAG_W-1:0]              s1_mag_q;
  logic signed [SH_W-1:0]        s1_sh_q;
  logic [IDX_W-1:0]              s1_index_q;
  logic [sli_pkg::VALUE_W-1:0]   s1_value_q;
  // stage 2: shifted magnitude
  logic                          s2_v_q;
  logic                          s2_load_q, s2_neg_q, s2_big_q;
  logic [POS_W-1:0]              s2_low_q;
  logic [IDX_W-1:0]              s2_index_q;
  logic [sli_pkg::VALUE_W-1:0]   s2_value_q;
  // stage 3: node index and weight
  logic                          s3_v_q;
  logic                          s3_load_q;
  logic [IDX_W-1:0]              s3_index_q, s3_index_d;
  logic [sli_pkg::VALUE_W-1:0]   s3_value_q;
  logic [F:0]                    s3_weight_q, s3_weight_d;

  logic                          rdy1, rdy2, rdy3;
  logic [sli_pkg::CODE_W-1:0]    abs_code;
  logic [MUL_W-1:0]              mul;
  logic signed [SH_W-1:0]        s1_sh_d;
  logic                          s2_big_d;
  logic [POS_W-1:0]              s2_low_d;
  logic [SH_W-1:0]               sh_u, n_u;
  logic [WIDE_W-1:0]             wide;
  logic [MAG_W-1:0]              trunc, rnd;
  logic                          over;
  logic [POS_W-1:0]              pos;

  // stall chain
  assign rdy3       = !s3_v_q || out_ready_i;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1 logic
  assign abs_code = code_i[sli_pkg::CODE_W-1] ? sli_pkg::CODE_W'(-code_i)
                                               : sli_pkg::CODE_W'(code_i);
  assign mul      = MUL_W'(abs_code) * MUL_W'(mantissa_i);
  assign s1_sh_d  = $signed({{(SH_W - sli_pkg::EXP_W){exponent_i[sli_pkg::EXP_W-1]}},
                             exponent_i}) + SH_W'(LOG2_NODES_PER_UNIT + F);

  // stage 2 logic: left shift with overflow flag, or rounding right shift
  always_comb begin
    sh_u     = s1_sh_q;
    n_u      = -sh_u;
    wide     = '0;
    trunc    = '0;
    rnd      = '0;
    s2_big_d = 1'b0;
    s2_low_d = '0;
    if (!s1_sh_q[SH_W-1]) begin
      if (sh_u >= SH_W'(POS_W)) begin
        s2_big_d = |s1_mag_q;
      end else begin
        wide     = WIDE_W'(s1_mag_q) << sh_u;
        s2_big_d = |wide[WIDE_W-1:POS_W];
        s2_low_d = wide[POS_W-1:0];
      end
    end else if (n_u <= SH_W'(MAG_W)) begin
      trunc    = s1_mag_q >> (n_u - SH_W'(1));
      rnd      = MAG_W'(({1'b0, trunc} + (MAG_W + 1)'(1)) >> 1);
      s2_big_d = |rnd[MAG_W-1:POS_W];
      s2_low_d = rnd[POS_W-1:0];
    end
  end

  // stage 3 logic: domain offset, clamp, index and weight
  always_comb begin
    over = s2_big_q || (s2_low_q > HALF_POS);
    if (over) begin
      pos = s2_neg_q ? '0 : TOP_POS;
    end else begin
      pos = s2_neg_q ? HALF_POS - s2_low_q : HALF_POS + s2_low_q;
    end
    if (pos == TOP_POS) begin
      s3_index_d  = IDX_MAX;
      s3_weight_d = W_ONE;
    end else begin
      s3_index_d  = IDX_W'(pos >> F);
      s3_weight_d = {1'b0, pos[F-1:0]};
    end
    if (s2_load_q) begin
      s3_index_d = s2_index_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_load_q  <= (mode_i == sli_pkg::MODE_LOAD);
      s1_neg_q   <= code_i[sli_pkg::CODE_W-1];
      s1_mag_q   <= mul[MAG_W-1:0];
      s1_sh_q    <= s1_sh_d;
      s1_index_q <= entry_index_i;
      s1_value_q <= entry_value_i;
    end
    if (rdy2) begin
      s2_load_q  <= s1_load_q;
      s2_neg_q   <= s1_neg_q;
      s2_big_q   <= s2_big_d;
      s2_low_q   <= s2_low_d;
      s2_index_q <= s1_index_q;
      s2_value_q <= s1_value_q;
    end
    if (rdy3) begin
      s3_load_q   <= s2_load_q;
      s3_index_q  <= s3_index_d;
      s3_value_q  <= s2_value_q;
      s3_weight_q <= s3_weight_d;
    end
  end

  assign out_valid_o  = s3_v_q;
  assign out_load_o   = s3_load_q;
  assign out_index_o  = s3_index_q;
  assign out_value_o  = s3_value_q;
  assign out_weight_o = s3_weight_q;

  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !s3_load_q) |-> (s3_weight_q <= W_ONE))
    else $error("weight above one node step");

  a_full_weight_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !s3_load_q && s3_weight_q[F]) |-> (s3_index_q == IDX_MAX))
    else $error("full weight away from last interval");

endmodule

`default_nettype wire

>>> rtl/sli_back.sv
// Back section: node table, two-node read, interpolation and rounding.
`default_nettype none

module sli_back #(
  parameter int unsigned TABLE_NODES            = sli_pkg::TABLE_NODES_DEF,
  parameter int unsigned POSITION_FRACTION_BITS = sli_pkg::POSITION_FRACTION_BITS_DEF,
  parameter int unsigned IDX_W                  = $clog2(TABLE_NODES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_load_i,
  input  logic [IDX_W-1:0]                in_index_i,
  input  logic [sli_pkg::VALUE_W-1:0]     in_value_i,
  input  logic [POSITION_FRACTION_BITS:0] in_weight_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sli_pkg::VALUE_W-1:0]     out_data_o
);

  localparam int unsigned F      = POSITION_FRACTION_BITS;
  localparam int unsigned VW     = sli_pkg::VALUE_W;
  localparam int unsigned DEPTH  = TABLE_NODES + 1;
  localparam int unsigned PROD_W = F + VW + 3;
  localparam int unsigned RND_W  = VW + 1;

  logic [VW-1:0]               node_table_q [DEPTH];

  logic                        b1_v_q, b2_v_q, b3_v_q;
  logic [VW-1:0]               b1_lo_q, b1_hi_q;
  logic [F:0]                  b1_w_q;
  logic signed [PROD_W-1:0]    b2_prod_q;
  logic [VW-1:0]               b2_lo_q, b3_lo_q;
  logic                        b3_neg_q;
  logic [RND_W-1:0]            b3_rnd_q, b3_rnd_d;

  logic                        rdy1, rdy2, rdy3, take;
  logic [IDX_W-1:0]            hi_idx;
  logic signed [VW:0]          diff;
  logic signed [PROD_W-1:0]    prod_d;
  logic [PROD_W-1:0]           prod_mag, prod_trunc, prod_rnd;
  logic [VW+1:0]               sum;

  assign rdy3       = !b3_v_q || out_ready_i;
  assign rdy2       = !b2_v_q || rdy3;
  assign rdy1       = !b1_v_q || rdy2;
  assign in_ready_o = rdy1;
  assign take       = in_valid_i && rdy1;
  assign hi_idx     = in_index_i + IDX_W'(1);

  // table write for loads, two-node read for evaluations
  always_ff @(posedge clk_i) begin
    if (take && in_load_i && (in_index_i <= IDX_W'(TABLE_NODES))) begin
      node_table_q[in_index_i] <= in_value_i;
    end
    if (take && !in_load_i) begin
      b1_lo_q <= node_table_q[in_index_i];
      b1_hi_q <= node_table_q[hi_idx];
      b1_w_q  <= in_weight_i;
    end
  end

  // weight times node difference
  assign diff   = $signed({1'b0, b1_hi_q}) - $signed({1'b0, b1_lo_q});
  assign prod_d = PROD_W'($signed({1'b0, b1_w_q})) * PROD_W'(diff);

  // symmetric rounding of the product by the fraction width
  always_comb begin
    prod_mag   = b2_prod_q[PROD_W-1] ? PROD_W'(-b2_prod_q) : PROD_W'(b2_prod_q);
    prod_trunc = prod_mag >> (F - 1);
    prod_rnd   = (prod_trunc + PROD_W'(1)) >> 1;
    b3_rnd_d   = prod_rnd[RND_W-1:0];
  end

  assign sum = b3_neg_q ? ({2'b00, b3_lo_q} - {1'b0, b3_rnd_q})
                        : ({2'b00, b3_lo_q} + {1'b0, b3_rnd_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
    end else begin
      if (rdy1) b1_v_q <= take && !in_load_i;
      if (rdy2) b2_v_q <= b1_v_q;
      if (rdy3) b3_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      b2_prod_q <= prod_d;
      b2_lo_q   <= b1_lo_q;
    end
    if (rdy3) begin
      b3_neg_q <= b2_prod_q[PROD_W-1];
      b3_rnd_q <= b3_rnd_d;
      b3_lo_q  <= b2_lo_q;
    end
  end

  assign out_valid_o = b3_v_q;
  assign out_data_o  = sum[VW-1:0];

endmodule

`default_nettype wire

>>> rtl/sigmoid_lut_interpolator.sv
// Top level of the sigmoid table interpolator.
//
// Usage: a table of TABLE_NODES+1 Q15 sigmoid nodes is loaded first with
// mode=1 words (entry_index, entry_value); load words give no result and
// indexes above TABLE_NODES are dropped. Mode=0 words carry a signed code
// that is scaled by scale_mantissa * 2^scale_exponent to a table position,
// clamped to the table, and interpolated between two nodes into sigmoid_q15.
// Input side: word taken on push && !full. Output side: head result shown
// while !empty, taken on pop && !empty.
// Throughput: one word per cycle, sustained, as long as results are popped.
// Path from accept to the output: 3 front stages (multiply, shift/round,
//   clamp), a mid queue slot, then table read, interpolation multiply and
//   rounding add, then an output queue slot.
// The 4-deep mid queue lets the front run while the table side stalls;
// the 2-deep output queue takes results while the receiver stalls, and
// full rises once both queues and the pipeline are backed up.
// Reset: queues and pipelines empty, registers to defaults; table contents
// are undefined until loaded. Config writes (cfg_we_i) only while idle.
`default_nettype none

module sigmoid_lut_interpolator #(
  parameter int unsigned TABLE_NODES            = sli_pkg::TABLE_NODES_DEF,
  parameter int unsigned LOG2_NODES_PER_UNIT    = sli_pkg::LOG2_NODES_PER_UNIT_DEF,
  parameter int unsigned POSITION_FRACTION_BITS = sli_pkg::POSITION_FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [sli_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [sli_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input queue side
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  mode_i,
  input  logic signed [sli_pkg::CODE_W-1:0]     code_i,
  input  logic [$clog2(TABLE_NODES + 1)-1:0]    entry_index_i,
  input  logic [sli_pkg::VALUE_W-1:0]           entry_value_i,
  // result queue side
  output logic                                  empty,
  input  logic                                  pop,
  output logic [sli_pkg::VALUE_W-1:0]           sigmoid_q15_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_NODES + 1);
  localparam int unsigned F       = POSITION_FRACTION_BITS;
  localparam int unsigned MID_W   = 1 + IDX_W + sli_pkg::VALUE_W + F + 1;

  logic [sli_pkg::MANT_W-1:0]        mant_q;
  logic signed [sli_pkg::EXP_W-1:0]  exp_q;

  // front -> mid queue
  logic                              fr_valid, fr_ready, fr_load;
  logic [IDX_W-1:0]                  fr_index;
  logic [sli_pkg::VALUE_W-1:0]       fr_value;
  logic [F:0]                        fr_weight;
  // mid queue -> back
  logic                              mq_valid, bk_ready, mq_load;
  logic [IDX_W-1:0]                  mq_index;
  logic [sli_pkg::VALUE_W-1:0]       mq_value;
  logic [F:0]                        mq_weight;
  // back -> output queue
  logic                              bk_valid, oq_ready, oq_valid;
  logic [sli_pkg::VALUE_W-1:0]       bk_data;
  logic                              fe_ready;

  // scale registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mant_q <= sli_pkg::MANT_RESET;
      exp_q  <= sli_pkg::EXP_RESET;
    end else if (cfg_we_i) begin
      case (sli_pkg::cfg_reg_e'(cfg_idx_i))
        sli_pkg::REG_SCALE_MANTISSA: mant_q <= cfg_data_i[sli_pkg::MANT_W-1:0];
        sli_pkg::REG_SCALE_EXPONENT: exp_q  <= $signed(cfg_data_i[sli_pkg::EXP_W-1:0]);
        default: ;
      endcase
    end
  end

  sli_front #(
    .TABLE_NODES            (TABLE_NODES),
    .LOG2_NODES_PER_UNIT    (LOG2_NODES_PER_UNIT),
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS),
    .IDX_W                  (IDX_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (push),
    .in_ready_o    (fe_ready),
    .mode_i        (mode_i),
    .code_i        (code_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .mantissa_i    (mant_q),
    .exponent_i    (exp_q),
    .out_valid_o   (fr_valid),
    .out_ready_i   (fr_ready),
    .out_load_o    (fr_load),
    .out_index_o   (fr_index),
    .out_value_o   (fr_value),
    .out_weight_o  (fr_weight)
  );

  assign full = !fe_ready;

  // decouples scaling from the table side
  sli_fifo #(
    .WIDTH (MID_W),
    .DEPTH (sli_pkg::MID_QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  ({fr_load, fr_index, fr_value, fr_weight}),
    .ready_o (fr_ready),
    .valid_o (mq_valid),
    .pop_i   (bk_ready),
    .data_o  ({mq_load, mq_index, mq_value, mq_weight})
  );

  sli_back #(
    .TABLE_NODES            (TABLE_NODES),
    .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS),
    .IDX_W                  (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mq_valid),
    .in_ready_o  (bk_ready),
    .in_load_i   (mq_load),
    .in_index_i  (mq_index),
    .in_value_i  (mq_value),
    .in_weight_i (mq_weight),
    .out_valid_o (bk_valid),
    .out_ready_i (oq_ready),
    .out_data_o  (bk_data)
  );

  // result queue: holds finished words while the receiver stalls
  sli_fifo #(
    .WIDTH (sli_pkg::VALUE_W),
    .DEPTH (sli_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_valid),
    .data_i  (bk_data),
    .ready_o (oq_ready),
    .valid_o (oq_valid),
    .pop_i   (pop),
    .data_o  (sigmoid_q15_o)
  );

  assign empty = !oq_valid;

endmodule

`default_nettype wire

>>> dv/sli_tb_pkg.sv
// Sigmoid interpolator tracker: table/scale mirror, expected-word store, result check.
`timescale 1ns / 100ps

package sli_tb_pkg;

  localparam int unsigned NODES         = sli_pkg::TABLE_NODES_DEF;
  localparam int unsigned FRAC_BITS     = sli_pkg::POSITION_FRACTION_BITS_DEF;
  localparam int unsigned LOG2_PER_UNIT = sli_pkg::LOG2_NODES_PER_UNIT_DEF;
  localparam int unsigned NODE_IDX_W    = $clog2(NODES + 1);
  // left-shifted position saturates at +-2^40
  localparam longint unsigned POSITION_SATURATION = 64'd1 << 40;

  class sigmoid_tracker;
    logic [sli_pkg::VALUE_W-1:0] nodes [0:NODES];
    logic [sli_pkg::MANT_W-1:0]  mantissa;
    int                          exponent;
    logic [sli_pkg::VALUE_W-1:0] sigmoid_due [$];
    int unsigned                 mismatches;

    function new();
      foreach (nodes[k]) nodes[k] = '0;
      mantissa   = sli_pkg::MANT_RESET;
      exponent   = int'(sli_pkg::EXP_RESET);
      mismatches = 0;
    endfunction

    function void set_register(sli_pkg::cfg_reg_e which,
                               logic [sli_pkg::CFG_DATA_W-1:0] data);
      case (which)
        sli_pkg::REG_SCALE_MANTISSA: mantissa = data[sli_pkg::MANT_W-1:0];
        sli_pkg::REG_SCALE_EXPONENT: exponent = int'($signed(data[sli_pkg::EXP_W-1:0]));
        default: ;
      endcase
    endfunction

    // ties go away from zero
    function longint round_half_away(longint v, int n);
      longint unsigned mag;
      bit              neg;
      if (n == 0) return v;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag + (64'd1 << (n - 1))) >> n;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function logic [sli_pkg::VALUE_W-1:0] sigmoid_at(
        logic signed [sli_pkg::CODE_W-1:0] code);
      longint          scaled;
      longint          pos;
      longint          top;
      longint          idx;
      longint          weight;
      longint          lower;
      longint          upper;
      longint unsigned mag;
      int              shift;
      bit              neg;
      scaled = longint'(code) * longint'(mantissa);
      shift  = exponent + int'(LOG2_PER_UNIT) + int'(FRAC_BITS);
      if (shift >= 0) begin
        neg = scaled < 0;
        mag = neg ? -scaled : scaled;
        if (mag != 0 && (shift > 40 || mag > (POSITION_SATURATION >> shift)))
          mag = POSITION_SATURATION;
        else
          mag = mag << shift;
        pos = neg ? -longint'(mag) : longint'(mag);
      end else if (shift <= -63) begin
        pos = 0;
      end else begin
        pos = round_half_away(scaled, -shift);
      end
      top = longint'(NODES) << FRAC_BITS;
      pos = pos + top / 2;
      if (pos < 0) pos = 0;
      else if (pos > top) pos = top;
      idx = pos >> FRAC_BITS;
      if (idx > longint'(NODES) - 1) idx = longint'(NODES) - 1;
      weight = pos - (idx << FRAC_BITS);
      lower  = longint'(nodes[idx]);
      upper  = longint'(nodes[idx + 1]);
      return sli_pkg::VALUE_W'(lower + round_half_away(weight * (upper - lower),
                                                       int'(FRAC_BITS)));
    endfunction

    function void note_word(sli_pkg::mode_e mode, logic signed [sli_pkg::CODE_W-1:0] code,
                            logic [NODE_IDX_W-1:0] index,
                            logic [sli_pkg::VALUE_W-1:0] value);
      if (mode == sli_pkg::MODE_LOAD) begin
        if (index <= NODES) nodes[index] = value;
      end else begin
        sigmoid_due.push_back(sigmoid_at(code));
      end
    endfunction

    function void check_sigmoid(logic [sli_pkg::VALUE_W-1:0] seen);
      logic [sli_pkg::VALUE_W-1:0] want;
      if (sigmoid_due.size() == 0) begin
        $display("%0t: sigmoid_q15 word with none expected: expected none, actual %0d",
                 $time, seen);
        mismatches++;
      end else begin
        want = sigmoid_due.pop_front();
        if (seen !== want) begin
          $display("%0t: sigmoid_q15 mismatch: expected %0d, actual %0d", $time, want, seen);
          mismatches++;
        end
      end
    endfunction

    function int unsigned waiting();
      return sigmoid_due.size();
    endfunction
  endclass

endpackage

>>> dv/tb_sigmoid_lut_interpolator.sv
// Top-level testbench for the sigmoid table interpolator.
`timescale 1ns / 100ps

module tb_sigmoid_lut_interpolator;

  localparam int unsigned PHASE_WORDS   = 76;   // counted words per scale setting
  localparam int unsigned SETTLE_CYCLES = 12;   // outlasts the pipeline path, covers trailing loads
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int unsigned HOLD_AT_WORD  = 715;
  localparam int unsigned QUIET_LIMIT   = 3000; // cycles with no word moving
  localparam int unsigned CODE_W        = sli_pkg::CODE_W;
  localparam int unsigned VALUE_W       = sli_pkg::VALUE_W;
  localparam int unsigned MANT_W        = sli_pkg::MANT_W;
  localparam int unsigned CFG_DATA_W    = sli_pkg::CFG_DATA_W;
  localparam int unsigned NODE_IDX_W    = sli_tb_pkg::NODE_IDX_W;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic [sli_pkg::CFG_IDX_W-1:0]     cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]             cfg_data_i    = '0;
  logic                              push          = 1'b0;
  logic                              full;
  logic                              mode_i        = 1'b0;
  logic signed [CODE_W-1:0]          code_i        = '0;
  logic [NODE_IDX_W-1:0]             entry_index_i = '0;
  logic [VALUE_W-1:0]                entry_value_i = '0;
  logic                              empty;
  logic                              pop           = 1'b0;
  logic [VALUE_W-1:0]                sigmoid_q15_o;

  sli_tb_pkg::sigmoid_tracker tracker;
  int unsigned    words_in    = 0;
  int unsigned    quiet_count = 0;
  bit             steady      = 1'b0;   // no idling on either side once set

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sigmoid_lut_interpolator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .code_i        (code_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .empty         (empty),
    .pop           (pop),
    .sigmoid_q15_o (sigmoid_q15_o)
  );

  // Monitor: everything sampled here is the pre-edge value, since all
  // drivers (ours and the block's) update through nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_register(sli_pkg::cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (push && !full) begin
        tracker.note_word(sli_pkg::mode_e'(mode_i), code_i, entry_index_i, entry_value_i);
        words_in <= words_in + 1;
      end
      if (pop && !empty) tracker.check_sigmoid(sigmoid_q15_o);
      quiet_count <= ((push && !full) || (pop && !empty)) ? 0 : quiet_count + 1;
    end
  end

  // Watchdog: a hang shows up as a long stretch with nothing moving.
  initial begin : watchdog
    while (quiet_count < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("[sigmoid_lut_interpolator] ERROR");
    $finish;
  end

  // Result side: random pop bursts, one long hold-off to back the block up
  // into full, then pop held high for the steady tail.
  initial begin : result_side
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && words_in >= HOLD_AT_WORD) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one word and hold it until the block takes it. Called at a clock
  // edge; returns at the edge where the word was accepted.
  task automatic send_word(sli_pkg::mode_e mode, logic [CODE_W-1:0] code,
                           logic [NODE_IDX_W-1:0] index, logic [VALUE_W-1:0] value);
    if (!steady && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push          <= 1'b1;
    mode_i        <= mode;
    code_i        <= code;
    entry_index_i <= index;
    entry_value_i <= value;
    do @(posedge clk_i); while (full);
  endtask

  // Node values: mostly in Q15 range, sometimes above one.
  function automatic logic [VALUE_W-1:0] pick_node_value();
    if ($urandom_range(0, 9) == 0) return VALUE_W'($urandom());
    return VALUE_W'($urandom_range(0, 32768));
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 15))
      0:       return 8'h80;   // most negative
      1:       return 8'h7F;   // most positive
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return CODE_W'($urandom());
    endcase
  endfunction

  // Drain everything in flight, then write both scale registers. The extra
  // edge lets the monitor note the last accepted word first.
  task automatic configure(logic [MANT_W-1:0] mant, int expo);
    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sli_pkg::REG_SCALE_MANTISSA;
    cfg_data_i <= CFG_DATA_W'(mant);
    @(posedge clk_i);
    cfg_idx_i  <= sli_pkg::REG_SCALE_EXPONENT;
    cfg_data_i <= CFG_DATA_W'(expo[sli_pkg::EXP_W-1:0]);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly lookups; some table rewrites; dropped out-of-range loads are
  // noise and do not count.
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        send_word(sli_pkg::MODE_EVAL, pick_code(), NODE_IDX_W'($urandom()),
                  VALUE_W'($urandom()));
        done++;
      end else if (pick < 95) begin
        send_word(sli_pkg::MODE_LOAD, CODE_W'($urandom()),
                  NODE_IDX_W'($urandom_range(0, 256)), pick_node_value());
        done++;
      end else begin
        send_word(sli_pkg::MODE_LOAD, CODE_W'($urandom()),
                  NODE_IDX_W'($urandom_range(257, 511)), VALUE_W'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    byte corner_codes [13] = '{-128, 127, 0, -1, 1, 7, 8, -8, -9, 3, -3, 64, -64};
    logic [MANT_W-1:0] mant;
    int                expo;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so no lookup ever reads an unwritten node.
    for (int n = 0; n <= int'(sli_pkg::TABLE_NODES_DEF); n++)
      send_word(sli_pkg::MODE_LOAD, CODE_W'($urandom()), NODE_IDX_W'(n), pick_node_value());

    // Directed, at reset scale (pos = code * 2^16 + half domain):
    // end nodes, a node above Q15 one, dropped loads, clamps at both ends,
    // and the top index clamp (code 8 lands exactly on the table end).
    send_word(sli_pkg::MODE_LOAD, 8'h00, 9'd0, 16'd0);
    send_word(sli_pkg::MODE_LOAD, 8'h00, 9'd256, 16'd32768);
    send_word(sli_pkg::MODE_LOAD, 8'h00, 9'd128, 16'hFFFF);
    send_word(sli_pkg::MODE_LOAD, 8'h00, 9'd300, 16'h1234);
    send_word(sli_pkg::MODE_LOAD, 8'hFF, 9'd511, 16'hFFFF);
    foreach (corner_codes[k])
      send_word(sli_pkg::MODE_EVAL, corner_codes[k], NODE_IDX_W'($urandom()),
                VALUE_W'($urandom()));
    run_random(PHASE_WORDS);

    // Extreme settings: large left shift with saturation, zero mantissa,
    // right shift past 62 bits, right shift by 62, minimal mantissa.
    configure(31'h7FFF_FFFF, 6);
    run_random(PHASE_WORDS);
    configure(31'd0, -31);
    run_random(PHASE_WORDS);
    configure(31'h4000_0000, -80);
    run_random(PHASE_WORDS);
    configure(31'h7FFF_FFFF, -79);
    run_random(PHASE_WORDS);
    configure(31'd1, 6);
    run_random(PHASE_WORDS);

    // Random settings, biased to spread codes across the table interior.
    for (int p = 0; p < 7; p++) begin
      mant = MANT_W'($urandom());
      if ($urandom_range(0, 3) == 0) mant = MANT_W'($urandom_range(0, 4096));
      if ($urandom_range(0, 3) == 0) expo = int'($urandom_range(0, 86)) - 80;
      else expo = int'($urandom_range(0, 12)) - 40;
      if (p == 6) steady = 1'b1;   // last stretch runs without idling
      configure(mant, expo);
      run_random(PHASE_WORDS);
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (tracker.mismatches == 0)
      $display("[sigmoid_lut_interpolator] OK");
    else
      $display("[sigmoid_lut_interpolator] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/sli_pkg.sv
rtl/sli_fifo.sv
rtl/sli_front.sv
rtl/sli_back.sv
rtl/sigmoid_lut_interpolator.sv
dv/sli_tb_pkg.sv
dv/tb_sigmoid_lut_interpolator.sv
